[rtl/core/simplex_fractal_height_assert.svh]
// Assertion macros shared by the RTL; clock and reset are taken from the including scope.
`ifndef SIMPLEX_FRACTAL_HEIGHT_ASSERT_SVH
`define SIMPLEX_FRACTAL_HEIGHT_ASSERT_SVH

// A property that must hold at every clock edge outside reset.
`define SFH_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// When the trigger holds, the property must hold in the next cycle.
`define SFH_ASSERT_NEXT(label, trig, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (prop)) \
        else $error(msg);

`endif

[rtl/core/sfh_pkg.sv]
package sfh_pkg;

    localparam int PERM_DEPTH = 512;
    localparam int PERM_AW    = 9;
    localparam int A_W        = 42;
    localparam int B_W        = 25;
    localparam int PROD_W     = A_W + B_W;
    localparam int CFG_IDX_W  = 4;

    localparam logic [B_W-1:0] SKEW_K      = 25'd383805;
    localparam logic [B_W-1:0] UNSKEW_K_B  = 25'd221590;
    localparam logic [23:0]    UNSKEW_K    = 24'd221590;
    localparam logic [23:0]    ONE_Q20     = 24'h100000;
    localparam logic [B_W-1:0] PERSIST_Q16 = 25'd42598;
    localparam logic [15:0]    AMP_START   = 16'd42598;

    localparam logic [CFG_IDX_W-1:0] CFG_FREQUENCY    = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OCTAVE_COUNT = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_HEIGHT   = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_SPAN  = 4'd3;

    typedef enum logic [4:0] {
        S_IDLE, S_MX, S_MY, S_SK0, S_OCT, S_CELL, S_UNSK, S_OFFS, S_CORN,
        S_H1A, S_H1B, S_H2A, S_H2B, S_SQX, S_SQY, S_TSUM, S_T2, S_T4, S_TG,
        S_ACC, S_NOISE, S_WEIGH, S_AMP, S_FINAL, S_RESULT
    } state_t;

    typedef struct packed {
        logic                  en;
        logic signed [A_W-1:0] a;
        logic signed [B_W-1:0] b;
    } mul_req_t;

    typedef struct packed {
        logic               we;
        logic [PERM_AW-1:0] waddr;
        logic [7:0]         wdata;
        logic [PERM_AW-1:0] raddr;
    } perm_req_t;

endpackage

[rtl/core/sfh_mul.sv]
module sfh_mul
    import sfh_pkg::*;
(
    input  logic                     clk,
    input  mul_req_t                 req,
    output logic signed [PROD_W-1:0] p_reg
);

    logic signed [PROD_W-1:0] prod;

    assign prod = PROD_W'(req.a) * PROD_W'(req.b);

    // The product register holds its value while no multiply is issued.
    always_ff @(posedge clk)
    begin
        if (req.en)
        begin
            p_reg <= prod;
        end
    end

endmodule

[rtl/core/sfh_perm_ram.sv]
module sfh_perm_ram
    import sfh_pkg::*;
(
    input  logic       clk,
    input  perm_req_t  req,
    output logic [7:0] rdata_reg
);

    logic [7:0] mem [PERM_DEPTH];

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        rdata_reg <= mem[req.raddr];
    end

endmodule

[rtl/core/simplex_fractal_height.sv]
// Fractal 2D simplex terrain height.
// Input channel (in_valid/in_ready): op = 0 writes perm_value into permutation entry
// perm_index in the accepting cycle and gives no result; op = 1 asks for the height at
// (x_coord, y_coord). A coordinate transaction is answered by one transaction on the
// output channel (out_valid/out_ready) carrying height.
// The configuration channel (cfg_valid/cfg_ready/cfg_index/cfg_data) is always ready;
// indices 0..3 select frequency, octave_count, low_height and height_span.
// One multiplier and one table read port are reused under a sequencer, so in_ready is
// high only while the sequencer is idle. Each octave of a coordinate is spent on
// skewing and six dependent table reads, on the multiplier for each simplex corner,
// and on weighting. The next transaction can be accepted in the same cycle as the
// result is presented.
// A finished result waits in the output register; while it is not taken the sequencer
// holds in its final state, and the next coordinate is accepted once it has moved on.
// Reset restores the register defaults and empties the output register; the
// permutation table is not cleared and must be loaded before heights are asked for.
`include "simplex_fractal_height_assert.svh"

module simplex_fractal_height
    import sfh_pkg::*;
#(
    parameter int MAX_OCTAVES = 8
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 op,
    input  logic [8:0]           x_coord,
    input  logic [8:0]           y_coord,
    input  logic [8:0]           perm_index,
    input  logic [7:0]           perm_value,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [8:0]           height,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [23:0]          cfg_data
);

    localparam logic [4:0] OCT_MAX = 5'(MAX_OCTAVES);

    state_t state_reg, state_next;

    logic [23:0] frequency_reg;
    logic [3:0]  octave_count_reg;
    logic [7:0]  low_height_reg;
    logic [5:0]  height_span_reg;

    logic [8:0]  x_reg, x_next, y_reg, y_next;
    logic [4:0]  oct_lim_reg, oct_lim_next, k_reg, k_next;
    logic [39:0] xs_reg, xs_next, ys_reg, ys_next;
    logic [20:0] ci_reg, ci_next, cj_reg, cj_next;
    logic signed [26:0] x0_reg, x0_next, y0_reg, y0_next;
    logic        i1_reg, i1_next;
    logic signed [26:0] dx_reg [3];
    logic signed [26:0] dx_next [3];
    logic signed [26:0] dy_reg [3];
    logic signed [26:0] dy_next [3];
    logic [2:0]  hash_reg [3];
    logic [2:0]  hash_next [3];
    logic [1:0]  cidx_reg, cidx_next;
    logic [26:0] sqx_reg, sqx_next;
    logic [19:0] t_reg, t_next;
    logic signed [25:0] acc_reg, acc_next;
    logic [15:0] amp_reg, amp_next;
    logic signed [31:0] total_reg, total_next;
    logic [8:0]  height_reg, height_next;
    logic        out_valid_reg, out_valid_next;

    mul_req_t                 mreq;
    logic signed [PROD_W-1:0] p;
    perm_req_t                preq;
    logic [7:0]               rdata;

    logic               in_fire;
    logic [39:0]        s_val;
    logic [40:0]        sx, sy;
    logic [21:0]        ij_sum;
    logic [26:0]        x0_calc, y0_calc;
    logic signed [26:0] cur_dx, cur_dy, u, v;
    logic [2:0]         cur_hash;
    logic signed [26:0] u27, v2, g;
    logic               corner_near;
    logic signed [28:0] t0;
    logic signed [31:0] acc32, n40;
    logic signed [27:0] noise;
    logic signed [31:0] clamped, shifted;
    logic [17:0]        norm;
    logic [8:0]         height_calc;
    logic               corner_last;

    sfh_mul u_mul
    (
        .clk   (clk),
        .req   (mreq),
        .p_reg (p)
    );

    sfh_perm_ram u_perm
    (
        .clk       (clk),
        .req       (preq),
        .rdata_reg (rdata)
    );

    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid & in_ready;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign height    = height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frequency_reg    <= 24'd16384;
            octave_count_reg <= 4'd6;
            low_height_reg   <= 8'd0;
            height_span_reg  <= 6'd32;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_FREQUENCY:    frequency_reg    <= cfg_data;
                CFG_OCTAVE_COUNT: octave_count_reg <= cfg_data[3:0];
                CFG_LOW_HEIGHT:   low_height_reg   <= cfg_data[7:0];
                CFG_HEIGHT_SPAN:  height_span_reg  <= cfg_data[5:0];
                default:          ;
            endcase
        end
    end

    // Datapath helpers, all fed from registers or the product register.
    // Far from the origin the skew and unskew constants drift apart by many cells,
    // so the cell offsets keep enough integer bits to stay exact.
    assign s_val   = p[59:20];
    assign sx      = {1'b0, xs_reg} + {1'b0, s_val};
    assign sy      = {1'b0, ys_reg} + {1'b0, s_val};
    assign ij_sum  = {1'b0, ci_reg} + {1'b0, cj_reg};
    assign x0_calc = xs_reg[26:0] - {ci_reg[6:0], 20'd0} + p[26:0];
    assign y0_calc = ys_reg[26:0] - {cj_reg[6:0], 20'd0} + p[26:0];

    assign cur_dx   = dx_reg[cidx_reg];
    assign cur_dy   = dy_reg[cidx_reg];
    assign cur_hash = hash_reg[cidx_reg];
    assign u        = cur_hash[2] ? cur_dy : cur_dx;
    assign v        = cur_hash[2] ? cur_dx : cur_dy;
    assign u27      = u;
    assign v2       = {v[25:0], 1'b0};
    assign g        = (cur_hash[0] ? -u27 : u27) + (cur_hash[1] ? -v2 : v2);

    // Offsets of two cells or more always fall outside the radius; the squares are
    // only exact below that.
    assign corner_near = (cur_dx[26:21] == {6{cur_dx[26]}})
                       && (cur_dy[26:21] == {6{cur_dy[26]}});

    assign t0 = 29'sd524288 - $signed({2'b00, sqx_reg}) - $signed({2'b00, p[46:20]});

    assign acc32 = {{6{acc_reg[25]}}, acc_reg};
    assign n40   = (acc32 <<< 5) + (acc32 <<< 3);
    assign noise = n40[31:4];

    always_comb
    begin
        if (total_reg > 32'sd65536)
        begin
            clamped = 32'sd65536;
        end
        else if (total_reg < -32'sd65536)
        begin
            clamped = -32'sd65536;
        end
        else
        begin
            clamped = total_reg;
        end
    end
    assign shifted     = clamped + 32'sd65536;
    assign norm        = shifted[17:0];
    assign height_calc = {1'b0, low_height_reg} + {2'b00, p[23:17]};
    assign corner_last = (cidx_reg == 2'd2);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            k_reg         <= 5'd0;
            oct_lim_reg   <= 5'd0;
            cidx_reg      <= 2'd0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            k_reg         <= k_next;
            oct_lim_reg   <= oct_lim_next;
            cidx_reg      <= cidx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg      <= x_next;
        y_reg      <= y_next;
        xs_reg     <= xs_next;
        ys_reg     <= ys_next;
        ci_reg     <= ci_next;
        cj_reg     <= cj_next;
        x0_reg     <= x0_next;
        y0_reg     <= y0_next;
        i1_reg     <= i1_next;
        dx_reg     <= dx_next;
        dy_reg     <= dy_next;
        hash_reg   <= hash_next;
        sqx_reg    <= sqx_next;
        t_reg      <= t_next;
        acc_reg    <= acc_next;
        amp_reg    <= amp_next;
        total_reg  <= total_next;
        height_reg <= height_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        oct_lim_next   = oct_lim_reg;
        k_next         = k_reg;
        xs_next        = xs_reg;
        ys_next        = ys_reg;
        ci_next        = ci_reg;
        cj_next        = cj_reg;
        x0_next        = x0_reg;
        y0_next        = y0_reg;
        i1_next        = i1_reg;
        dx_next        = dx_reg;
        dy_next        = dy_reg;
        hash_next      = hash_reg;
        cidx_next      = cidx_reg;
        sqx_next       = sqx_reg;
        t_next         = t_reg;
        acc_next       = acc_reg;
        amp_next       = amp_reg;
        total_next     = total_reg;
        height_next    = height_reg;
        out_valid_next = out_valid_reg & ~out_ready;

        mreq.en = 1'b0;
        mreq.a  = '0;
        mreq.b  = '0;

        preq.we    = in_fire & ~op;
        preq.waddr = perm_index;
        preq.wdata = perm_value;
        preq.raddr = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire && op)
                begin
                    x_next     = x_coord;
                    y_next     = y_coord;
                    k_next     = 5'd0;
                    total_next = '0;
                    amp_next   = AMP_START;
                    if ({1'b0, octave_count_reg} > OCT_MAX)
                    begin
                        oct_lim_next = OCT_MAX;
                    end
                    else
                    begin
                        oct_lim_next = {1'b0, octave_count_reg};
                    end
                    state_next = S_MX;
                end
            end
            S_MX:
            begin
                mreq.en    = 1'b1;
                mreq.a     = {33'd0, x_reg};
                mreq.b     = {1'b0, frequency_reg};
                state_next = S_MY;
            end
            S_MY:
            begin
                mreq.en    = 1'b1;
                mreq.a     = {33'd0, y_reg};
                mreq.b     = {1'b0, frequency_reg};
                xs_next    = p[39:0];
                state_next = S_SK0;
            end
            S_SK0:
            begin
                ys_next = p[39:0];
                if (oct_lim_reg == 5'd0)
                begin
                    state_next = S_FINAL;
                end
                else
                begin
                    state_next = S_OCT;
                end
            end
            S_OCT:
            begin
                mreq.en    = 1'b1;
                mreq.a     = {1'b0, ({1'b0, xs_reg} + {1'b0, ys_reg})};
                mreq.b     = SKEW_K;
                state_next = S_CELL;
            end
            S_CELL:
            begin
                ci_next    = sx[40:20];
                cj_next    = sy[40:20];
                state_next = S_UNSK;
            end
            S_UNSK:
            begin
                mreq.en    = 1'b1;
                mreq.a     = {20'd0, ij_sum};
                mreq.b     = UNSKEW_K_B;
                preq.raddr = {1'b0, cj_reg[7:0]};
                state_next = S_OFFS;
            end
            S_OFFS:
            begin
                x0_next    = $signed(x0_calc);
                y0_next    = $signed(y0_calc);
                preq.raddr = {1'b0, ci_reg[7:0]} + {1'b0, rdata};
                state_next = S_CORN;
            end
            S_CORN:
            begin
                // The middle corner steps along x when x0 exceeds y0, else along y.
                i1_next      = (x0_reg > y0_reg);
                dx_next[0]   = x0_reg;
                dy_next[0]   = y0_reg;
                dx_next[1]   = x0_reg - ((x0_reg > y0_reg) ? {3'd0, ONE_Q20} : 27'd0)
                             + {3'd0, UNSKEW_K};
                dy_next[1]   = y0_reg - ((x0_reg > y0_reg) ? 27'd0 : {3'd0, ONE_Q20})
                             + {3'd0, UNSKEW_K};
                dx_next[2]   = x0_reg - {3'd0, ONE_Q20} + {3'd0, UNSKEW_K[22:0], 1'b0};
                dy_next[2]   = y0_reg - {3'd0, ONE_Q20} + {3'd0, UNSKEW_K[22:0], 1'b0};
                hash_next[0] = rdata[2:0];
                preq.raddr   = {1'b0, cj_reg[7:0]} + ((x0_reg > y0_reg) ? 9'd0 : 9'd1);
                state_next   = S_H1A;
            end
            S_H1A:
            begin
                preq.raddr = {1'b0, ci_reg[7:0]} + {8'd0, i1_reg} + {1'b0, rdata};
                state_next = S_H1B;
            end
            S_H1B:
            begin
                hash_next[1] = rdata[2:0];
                preq.raddr   = {1'b0, cj_reg[7:0]} + 9'd1;
                state_next   = S_H2A;
            end
            S_H2A:
            begin
                preq.raddr = {1'b0, ci_reg[7:0]} + 9'd1 + {1'b0, rdata};
                state_next = S_H2B;
            end
            S_H2B:
            begin
                hash_next[2] = rdata[2:0];
                cidx_next    = 2'd0;
                acc_next     = '0;
                state_next   = S_SQX;
            end
            S_SQX:
            begin
                mreq.en    = 1'b1;
                mreq.a     = {{15{cur_dx[26]}}, cur_dx};
                mreq.b     = cur_dx[24:0];
                state_next = S_SQY;
            end
            S_SQY:
            begin
                mreq.en    = 1'b1;
                mreq.a     = {{15{cur_dy[26]}}, cur_dy};
                mreq.b     = cur_dy[24:0];
                sqx_next   = p[46:20];
                state_next = S_TSUM;
            end
            S_TSUM:
            begin
                // A corner outside its radius contributes nothing.
                if (t0[28] || !corner_near)
                begin
                    if (corner_last)
                    begin
                        state_next = S_NOISE;
                    end
                    else
                    begin
                        cidx_next  = cidx_reg + 2'd1;
                        state_next = S_SQX;
                    end
                end
                else
                begin
                    t_next     = t0[19:0];
                    state_next = S_T2;
                end
            end
            S_T2:
            begin
                mreq.en    = 1'b1;
                mreq.a     = {22'd0, t_reg};
                mreq.b     = {5'd0, t_reg};
                state_next = S_T4;
            end
            S_T4:
            begin
                mreq.en    = 1'b1;
                mreq.a     = {22'd0, p[39:20]};
                mreq.b     = {5'd0, p[39:20]};
                state_next = S_TG;
            end
            S_TG:
            begin
                mreq.en    = 1'b1;
                mreq.a     = {{15{g[26]}}, g};
                mreq.b     = {5'd0, p[39:20]};
                state_next = S_ACC;
            end
            S_ACC:
            begin
                acc_next = acc_reg + $signed(p[45:20]);
                if (corner_last)
                begin
                    state_next = S_NOISE;
                end
                else
                begin
                    cidx_next  = cidx_reg + 2'd1;
                    state_next = S_SQX;
                end
            end
            S_NOISE:
            begin
                mreq.en    = 1'b1;
                mreq.a     = {{14{noise[27]}}, noise};
                mreq.b     = {9'd0, amp_reg};
                state_next = S_WEIGH;
            end
            S_WEIGH:
            begin
                mreq.en    = 1'b1;
                mreq.a     = {26'd0, amp_reg};
                mreq.b     = PERSIST_Q16;
                total_next = total_reg + $signed(p[47:16]);
                state_next = S_AMP;
            end
            S_AMP:
            begin
                amp_next = p[31:16];
                xs_next  = {xs_reg[38:0], 1'b0};
                ys_next  = {ys_reg[38:0], 1'b0};
                k_next   = k_reg + 5'd1;
                if (k_reg + 5'd1 < oct_lim_reg)
                begin
                    state_next = S_OCT;
                end
                else
                begin
                    state_next = S_FINAL;
                end
            end
            S_FINAL:
            begin
                mreq.en    = 1'b1;
                mreq.a     = {24'd0, norm};
                mreq.b     = {19'd0, height_span_reg};
                state_next = S_RESULT;
            end
            S_RESULT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    height_next    = height_calc;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    `SFH_ASSERT(a_octave_bound, k_reg <= oct_lim_reg, "octave counter passed its limit")
    `SFH_ASSERT(a_corner_bound, cidx_reg <= 2'd2, "corner index out of range")
    `SFH_ASSERT_NEXT(a_coord_start, in_fire && op, state_reg == S_MX, "coordinate not started")
    `SFH_ASSERT_NEXT(a_result_out, state_reg == S_RESULT && (!out_valid_reg || out_ready),
        out_valid_reg && state_reg == S_IDLE, "result transaction not presented")

endmodule

[bench/simplex_fractal_height_tb.sv]
module simplex_fractal_height_tb;
    import sfh_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int  LIMIT_CYCLES = 1500000;
    localparam int  N_RANDOM     = 560;
    localparam logic [CFG_IDX_W-1:0] CFG_NONE = 4'd9;
    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_HEIGHT = 1'b1;
    localparam longint COORD_MASK = (longint'(1) << 40) - 1;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic op;
    logic [8:0] x_coord;
    logic [8:0] y_coord;
    logic [8:0] perm_index;
    logic [7:0] perm_value;
    logic out_valid;
    logic out_ready;
    logic [8:0] height;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [23:0] cfg_data;

    // Shadow of the block's registers and permutation table.
    logic [7:0]  perm_shadow [PERM_DEPTH];
    logic [23:0] freq_q;
    logic [3:0]  octaves_q;
    logic [7:0]  low_q;
    logic [5:0]  span_q;

    logic [8:0] height_q [$];
    int  error_count;
    int  heights_checked;
    int  loads_sent;
    int  cycle_count;
    bit  no_idle;
    int  hold_cycles;
    int  rx_gap;

    simplex_fractal_height u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .op         (op),
        .x_coord    (x_coord),
        .y_coord    (y_coord),
        .perm_index (perm_index),
        .perm_value (perm_value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .height     (height),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    function automatic longint corner_weight(longint dx, longint dy, logic [7:0] hash);
        longint t;
        longint u;
        longint v;
        longint g;
        logic [2:0] h;
        h = hash[2:0];
        t = 524288 - ((dx * dx) >>> 20) - ((dy * dy) >>> 20);
        if (t < 0)
            return 0;
        t = (t * t) >>> 20;
        t = (t * t) >>> 20;
        u = (h < 4) ? dx : dy;
        v = (h < 4) ? dy : dx;
        g = (h[0] ? -u : u) + (h[1] ? -2 * v : 2 * v);
        return (t * g) >>> 20;
    endfunction

    function automatic logic [7:0] perm_at(longint idx);
        return perm_shadow[idx & (PERM_DEPTH - 1)];
    endfunction

    // One octave of simplex noise at a Q20 sample point, returned in Q3.16.
    function automatic longint simplex_noise(longint px, longint py);
        longint s;
        longint ci;
        longint cj;
        longint t;
        longint x0;
        longint y0;
        longint x1;
        longint y1;
        longint x2;
        longint y2;
        longint i1;
        longint ii;
        longint jj;
        longint g2;
        longint sum;
        g2 = longint'(UNSKEW_K);
        s  = ((px + py) * longint'(SKEW_K)) >>> 20;
        ci = (px + s) >>> 20;
        cj = (py + s) >>> 20;
        t  = (ci + cj) * g2;
        x0 = px - (ci <<< 20) + t;
        y0 = py - (cj <<< 20) + t;
        i1 = (x0 > y0) ? 1 : 0;
        x1 = x0 - (i1 <<< 20) + g2;
        y1 = y0 - ((1 - i1) <<< 20) + g2;
        x2 = x0 - (longint'(1) <<< 20) + 2 * g2;
        y2 = y0 - (longint'(1) <<< 20) + 2 * g2;
        ii = ci & 255;
        jj = cj & 255;
        sum = corner_weight(x0, y0, perm_at(ii + perm_at(jj)))
            + corner_weight(x1, y1, perm_at(ii + i1 + perm_at(jj + 1 - i1)))
            + corner_weight(x2, y2, perm_at(ii + 1 + perm_at(jj + 1)));
        return (40 * sum) >>> 4;
    endfunction

    function automatic logic [8:0] terrain_height(logic [8:0] x, logic [8:0] y);
        longint total;
        longint amp;
        longint px;
        longint py;
        longint h;
        int     oct;
        total = 0;
        amp = longint'(PERSIST_Q16);
        oct = (octaves_q > 8) ? 8 : int'(octaves_q);
        for (int k = 0; k < oct; k++)
        begin
            px = ((longint'(x) * longint'(freq_q)) << k) & COORD_MASK;
            py = ((longint'(y) * longint'(freq_q)) << k) & COORD_MASK;
            total += (simplex_noise(px, py) * amp) >>> 16;
            amp = (amp * longint'(PERSIST_Q16)) >>> 16;
        end
        if (total > 65536)
            total = 65536;
        if (total < -65536)
            total = -65536;
        h = longint'(low_q) + (((total + 65536) * longint'(span_q)) >>> 17);
        return h[8:0];
    endfunction

    // Result side: random stalls per transaction, plus a long hold-off on request.
    always @(posedge clk or negedge rst_n)
    begin
        logic [8:0] want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            rx_gap = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (height_q.size() == 0)
                begin
                    $error("height transaction with nothing expected: %0d", height);
                    error_count++;
                end
                else
                begin
                    want = height_q.pop_front();
                    heights_checked++;
                    if (height !== want)
                    begin
                        $error("height mismatch: expected %0d, actual %0d", want, height);
                        error_count++;
                    end
                end
                rx_gap = no_idle ? 0 : $urandom_range(0, 11);
            end
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                out_ready <= 1'b0;
            end
            else if (rx_gap > 0)
            begin
                rx_gap--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("Timed out with %0d heights outstanding", height_q.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic send_item(logic o, logic [8:0] x, logic [8:0] y,
                             logic [8:0] pi, logic [7:0] pv);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 11);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        op         <= o;
        x_coord    <= x;
        y_coord    <= y;
        perm_index <= pi;
        perm_value <= pv;
        do
            @(posedge clk);
        while (!in_ready);
        if (o == OP_LOAD)
        begin
            perm_shadow[pi] = pv;
            loads_sent++;
        end
        else
            height_q.push_back(terrain_height(x, y));
    endtask

    task automatic send_height(logic [8:0] x, logic [8:0] y);
        send_item(OP_HEIGHT, x, y, 9'($urandom), 8'($urandom));
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        @(posedge clk);
        while (height_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    // Only called with the block drained.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [23:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_FREQUENCY:    freq_q    = data;
            CFG_OCTAVE_COUNT: octaves_q = data[3:0];
            CFG_LOW_HEIGHT:   low_q     = data[7:0];
            CFG_HEIGHT_SPAN:  span_q    = data[5:0];
            default: ;
        endcase
    endtask

    task automatic configure(logic [23:0] f, logic [23:0] oc, logic [23:0] lo, logic [23:0] sp);
        write_reg(CFG_FREQUENCY, f);
        write_reg(CFG_OCTAVE_COUNT, oc);
        write_reg(CFG_LOW_HEIGHT, lo);
        write_reg(CFG_HEIGHT_SPAN, sp);
    endtask

    // The whole table must hold data before any height is asked for.
    task automatic test_table_load;
        for (int i = 0; i < PERM_DEPTH; i++)
            send_item(OP_LOAD, 9'($urandom), 9'($urandom), 9'(i), 8'($urandom));
        send_item(OP_LOAD, 9'd0, 9'd0, 9'd0, 8'h00);
        send_item(OP_LOAD, 9'd511, 9'd511, 9'd511, 8'hff);
    endtask

    task automatic test_reset_defaults;
        send_height(9'd0, 9'd0);
        send_height(9'd511, 9'd511);
        send_height(9'd100, 9'd37);
        drain();
    endtask

    task automatic test_directed_extremes;
        // Largest frequency and octaves: sample points wrap modulo 2^40.
        configure(24'hffffff, 24'd8, 24'd255, 24'd63);
        send_height(9'd511, 9'd511);
        send_height(9'd0, 9'd511);
        send_height(9'd511, 9'd0);
        send_height(9'd0, 9'd0);
        drain();
        // No octaves: the height is the low height plus half the span.
        configure(24'd0, 24'd0, 24'd17, 24'd63);
        send_height(9'd3, 9'd4);
        send_height(9'd511, 9'd1);
        drain();
        // Octave counts above the maximum are capped; upper bits of data are dropped.
        configure(24'd65536, 24'hfffff, 24'hffff00, 24'hffffc0);
        write_reg(CFG_NONE, 24'h123456);
        send_height(9'd200, 9'd300);
        send_height(9'd1, 9'd510);
        drain();
        configure(24'd1, 24'd1, 24'd0, 24'd0);
        send_height(9'd511, 9'd511);
        send_height(9'd256, 9'd255);
        drain();
    endtask

    // Receiver holds off while the sender keeps offering, so the input stalls.
    task automatic test_backpressure;
        configure(24'd16384, 24'd2, 24'd10, 24'd40);
        hold_cycles = 600;
        no_idle = 1'b1;
        for (int i = 0; i < 12; i++)
            send_height(9'($urandom), 9'($urandom));
        no_idle = 1'b0;
        drain();
    endtask

    task automatic test_random;
        for (int n = 0; n < N_RANDOM; n++)
        begin
            if (n % 100 == 0)
            begin
                drain();
                no_idle = ($urandom_range(0, 3) == 0);
                configure($urandom_range(0, 1) ? 24'($urandom) : 24'($urandom_range(0, 65536)),
                          24'($urandom_range(0, 100) < 85 ? $urandom_range(1, 3)
                                                          : $urandom_range(0, 15)),
                          24'($urandom), 24'($urandom));
            end
            if ($urandom_range(0, 9) < 2)
                send_item(OP_LOAD, 9'($urandom), 9'($urandom), 9'($urandom), 8'($urandom));
            else
                send_height(9'($urandom), 9'($urandom));
        end
        no_idle = 1'b0;
        drain();
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        op = OP_LOAD;
        x_coord = '0;
        y_coord = '0;
        perm_index = '0;
        perm_value = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_FREQUENCY;
        cfg_data = '0;
        error_count = 0;
        heights_checked = 0;
        loads_sent = 0;
        cycle_count = 0;
        no_idle = 1'b0;
        hold_cycles = 0;
        freq_q = 24'd16384;
        octaves_q = 4'd6;
        low_q = 8'd0;
        span_q = 6'd32;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_table_load();
        test_reset_defaults();
        test_directed_extremes();
        test_backpressure();
        test_random();

        $display("Checked %0d heights and sent %0d table loads in %0d cycles,",
                 heights_checked, loads_sent, cycle_count);
        $display("across default, extreme and random register settings with stalls.");
        if (error_count == 0 && height_q.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl/core
rtl/core/sfh_pkg.sv
rtl/core/sfh_mul.sv
rtl/core/sfh_perm_ram.sv
rtl/core/simplex_fractal_height.sv
bench/simplex_fractal_height_tb.sv
